/* rtl/core/swad_pkg.sv */
package swad_pkg;

   // Fixed field widths of the request and response words
   localparam int LETTER_W = 5;
   localparam int ACTION_W = 2;

   // Request action codes; the fourth code carries no meaning and is ignored
   typedef enum logic [ACTION_W-1:0] {
      ACT_BEGIN   = 2'd0,
      ACT_PATTERN = 2'd1,
      ACT_TEXT    = 2'd2
   } action_type;

   // Histogram update controls for one accepted word
   typedef struct packed {
      logic                clear;
      logic                pat_inc;
      logic                win_inc;
      logic                win_dec;
      logic [LETTER_W-1:0] new_letter;
      logic [LETTER_W-1:0] old_letter;
   } hist_ctl_type;

   // Response word as it is buffered toward the response channel
   typedef struct packed {
      logic window_match;
      logic found;
      logic pattern_overflow;
   } rsp_word_type;

endpackage

/* rtl/core/swad_if.sv */
interface swad_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [4:0] letter;

   modport source (output valid, output action, output letter, input ready);
   modport sink   (input valid, input action, input letter, output ready);
endinterface

interface swad_rsp_if;
   logic valid;
   logic ready;
   logic window_match;
   logic found;
   logic pattern_overflow;

   modport source (output valid, output window_match, output found,
                   output pattern_overflow, input ready);
   modport sink   (input valid, input window_match, input found,
                   input pattern_overflow, output ready);
endinterface

/* rtl/core/swad_ram.sv */
module swad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the contents before a write to the same address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/swad_hist.sv */
module swad_hist
   import swad_pkg::*;
#(
   parameter int ALPHABET = 26,
   parameter int CNT_W    = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  hist_ctl_type ctl,
   output logic         equal_next
);

   logic [CNT_W-1:0]    pat_ff [ALPHABET];
   logic [CNT_W-1:0]    pat_in [ALPHABET];
   logic [CNT_W-1:0]    win_ff [ALPHABET];
   logic [CNT_W-1:0]    win_in [ALPHABET];
   logic [ALPHABET-1:0] eq_bits;

   // Each bin updates itself from the decoded letters; compare on next values
   always_comb begin
      for (int i = 0; i < ALPHABET; i++) begin
         if (ctl.clear) begin
            pat_in[i] = '0;
            win_in[i] = '0;
         end else begin
            pat_in[i] = pat_ff[i]
                      + CNT_W'(ctl.pat_inc && (int'(ctl.new_letter) == i));
            win_in[i] = win_ff[i]
                      + CNT_W'(ctl.win_inc && (int'(ctl.new_letter) == i))
                      - CNT_W'(ctl.win_dec && (int'(ctl.old_letter) == i)
                               && (win_ff[i] != '0));
         end
         eq_bits[i] = (pat_in[i] == win_in[i]);
      end
   end

   assign equal_next = &eq_bits;

   always_ff @(posedge clock) begin
      for (int i = 0; i < ALPHABET; i++) begin
         if (reset) begin
            pat_ff[i] <= '0;
            win_ff[i] <= '0;
         end else begin
            pat_ff[i] <= pat_in[i];
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

/* rtl/core/sliding_window_anagram_detector.sv */
// Sliding-window anagram detector. Send a begin word, then the pattern letters,
// then the text letters (indices a=0 .. z=25). Every request word returns exactly
// one response word: window_match is high when the last pattern-length text
// letters are a permutation of the pattern, found stays high once any window has
// matched, and pattern_overflow stays high once the pattern ran past MAX_PATTERN
// letters (the extra letters are dropped and the truncated pattern is used).
// Pattern letters arriving after text has started, letters at or above ALPHABET
// and the unused action code change nothing and report no match. The block takes
// one word per clock while the skid entry is free; the response word is registered. Two
// response entries (output register plus a skid entry) let a new word enter while
// a response is still waiting. The rate is set by the histogram update and the
// ALPHABET-wide compare, done combinationally on next values, and by the ring of recent
// text letters, a MAX_PATTERN-deep RAM whose oldest entry is read ahead at the next write slot.
module sliding_window_anagram_detector
   import swad_pkg::*;
#(
   parameter int MAX_PATTERN = 64,
   parameter int ALPHABET    = 26
) (
   input  logic         clock,
   input  logic         reset,
   swad_req_if.sink     req_ch,
   swad_rsp_if.source   rsp_ch
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // Request side
   logic req_fire;
   logic letter_ok;

   // Scan state
   logic [LEN_W-1:0] len_ff,   len_in;
   logic [LEN_W-1:0] fill_ff,  fill_in;
   logic [PTR_W-1:0] ptr_ff,   ptr_in;
   logic             found_ff, found_in;
   logic             ovf_ff,   ovf_in;

   logic [PTR_W-1:0] ptr_eff;
   logic [LEN_W-1:0] ptr_step;
   logic             text_go;
   logic             match;

   // Letter ring
   logic                ram_we;
   logic [LETTER_W-1:0] ram_rd_data;
   logic                bypass_ff;
   logic [LETTER_W-1:0] bypass_data_ff;
   logic [LETTER_W-1:0] old_letter;

   // Histograms
   hist_ctl_type hist_ctl;
   logic         hist_equal;

   // Response buffer
   rsp_word_type rsp_word;
   rsp_word_type head_ff;
   rsp_word_type skid_ff;
   logic         head_valid_ff;
   logic         skid_valid_ff;
   logic         rsp_pop;

   // Stall input only when both response entries are occupied
   assign req_ch.ready = !skid_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign letter_ok    = int'(req_ch.letter) < ALPHABET;

   // Oldest ring entry: prefetched last cycle, or the letter just written there
   assign old_letter = bypass_ff ? bypass_data_ff : ram_rd_data;

   always_comb begin
      len_in   = len_ff;
      fill_in  = fill_ff;
      ptr_in   = ptr_ff;
      found_in = found_ff;
      ovf_in   = ovf_ff;
      hist_ctl = '0;
      hist_ctl.new_letter = req_ch.letter;
      hist_ctl.old_letter = old_letter;
      ram_we   = 1'b0;
      text_go  = 1'b0;
      match    = 1'b0;

      // Wrap the write slot if it ever sits at or past the pattern length
      ptr_eff  = (LEN_W'(ptr_ff) >= len_ff) ? '0 : ptr_ff;
      ptr_step = LEN_W'(ptr_eff) + LEN_W'(1);

      if (req_fire) begin
         unique case (action_type'(req_ch.action))
            ACT_BEGIN: begin
               // Drop all state; the response reports all zeros
               len_in         = '0;
               fill_in        = '0;
               ptr_in         = '0;
               found_in       = 1'b0;
               ovf_in         = 1'b0;
               hist_ctl.clear = 1'b1;
            end
            ACT_PATTERN: begin
               // Pattern grows only while the window is still empty
               if (letter_ok && (fill_ff == '0)) begin
                  if (len_ff >= LEN_W'(MAX_PATTERN)) begin
                     ovf_in = 1'b1;
                  end else begin
                     len_in           = len_ff + LEN_W'(1);
                     hist_ctl.pat_inc = 1'b1;
                  end
               end
            end
            ACT_TEXT: begin
               // An empty pattern discards text letters
               if (letter_ok && (len_ff != '0)) begin
                  text_go          = 1'b1;
                  ram_we           = 1'b1;
                  hist_ctl.win_inc = 1'b1;
                  if (fill_ff >= len_ff) begin
                     hist_ctl.win_dec = 1'b1;
                  end else begin
                     fill_in = fill_ff + LEN_W'(1);
                  end
                  ptr_in = (ptr_step >= len_ff) ? '0 : PTR_W'(ptr_step);
               end
            end
            default: begin
            end
         endcase
      end

      match    = text_go && (fill_in == len_ff) && hist_equal;
      found_in = found_in || match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         fill_ff  <= '0;
         ptr_ff   <= '0;
         found_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         ptr_ff   <= ptr_in;
         found_ff <= found_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Read ahead at the next write slot; forward when that slot is written now
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else begin
         bypass_ff <= ram_we && (ptr_eff == ptr_in);
      end
      bypass_data_ff <= req_ch.letter;
   end

   swad_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (MAX_PATTERN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ptr_eff),
      .wr_data (req_ch.letter),
      .rd_addr (ptr_in),
      .rd_data (ram_rd_data)
   );

   swad_hist #(
      .ALPHABET (ALPHABET),
      .CNT_W    (LEN_W)
   ) u_hist (
      .clock      (clock),
      .reset      (reset),
      .ctl        (hist_ctl),
      .equal_next (hist_equal)
   );

   // Response word for the accepted request
   assign rsp_word.window_match     = match;
   assign rsp_word.found            = found_in;
   assign rsp_word.pattern_overflow = ovf_in;

   assign rsp_pop = head_valid_ff && rsp_ch.ready;

   // Two-entry response buffer: advance skid into head when head drains
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!head_valid_ff || rsp_pop) begin
         head_valid_ff <= skid_valid_ff || req_fire;
         skid_valid_ff <= skid_valid_ff && req_fire;
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!head_valid_ff || rsp_pop) begin
         head_ff <= skid_valid_ff ? skid_ff : rsp_word;
         skid_ff <= rsp_word;
      end else if (req_fire) begin
         skid_ff <= rsp_word;
      end
   end

   assign rsp_ch.valid            = head_valid_ff;
   assign rsp_ch.window_match     = head_ff.window_match;
   assign rsp_ch.found            = head_ff.found;
   assign rsp_ch.pattern_overflow = head_ff.pattern_overflow;

`ifndef SYNTHESIS
   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held without a head entry");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond MAX_PATTERN");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_ff)
      else $error("window fill beyond pattern length");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != '0) |-> (LEN_W'(ptr_ff) < len_ff))
      else $error("ring pointer outside the window");

   a_begin_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.action == ACT_BEGIN))
      |=> ((len_ff == '0) && (fill_ff == '0) && !found_ff && !ovf_ff))
      else $error("begin did not clear the scan state");
`endif

endmodule

/* sim/sliding_window_anagram_detector_test.sv */
`timescale 1ns / 100ps

module sliding_window_anagram_detector_test;
   import swad_pkg::*;

   localparam int MAX_PATTERN = 64;
   localparam int ALPHABET    = 26;
   // The fourth action code has no name in the package; the block ignores it
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 2000;
   localparam int PRINT_LIMIT = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swad_req_if req_ch ();
   swad_rsp_if rsp_ch ();

   sliding_window_anagram_detector #(
      .MAX_PATTERN(MAX_PATTERN),
      .ALPHABET(ALPHABET)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #5 clock = ~clock;

   // Predicted copy of the detector state
   logic [6:0] pattern_hist [ALPHABET];
   logic [6:0] window_hist  [ALPHABET];
   logic [4:0] text_ring    [MAX_PATTERN];
   logic [6:0] pattern_len;
   logic [6:0] window_len;
   logic [5:0] ring_index;
   logic       seen_match;
   logic       pattern_spilled;

   rsp_word_type expected_rsp [$];
   int error_count = 0;
   int cycle_count = 0;
   int words_sent  = 0;
   bit no_idle     = 1'b0;
   int stall_left  = 0;

   // Clear the predicted state, as reset or a begin word does
   function automatic void clear_prediction();
      for (int i = 0; i < ALPHABET; i++) begin
         pattern_hist[i] = '0;
         window_hist[i]  = '0;
      end
      pattern_len     = '0;
      window_len      = '0;
      ring_index      = '0;
      seen_match      = 1'b0;
      pattern_spilled = 1'b0;
   endfunction

   // Advance the predicted state by one accepted word and return its response
   function automatic rsp_word_type predict_response(logic [1:0] action, logic [4:0] letter);
      rsp_word_type rsp;
      logic [4:0]   oldest;
      logic         same;
      rsp.window_match = 1'b0;
      if (action == ACT_BEGIN) begin
         clear_prediction();
      end else if (letter < ALPHABET) begin
         if (action == ACT_PATTERN) begin
            // Pattern letters count only before any text has entered the window
            if (window_len == 0) begin
               if (pattern_len >= MAX_PATTERN) begin
                  pattern_spilled = 1'b1;
               end else begin
                  pattern_hist[letter]++;
                  pattern_len++;
               end
            end
         end else if (action == ACT_TEXT && pattern_len != 0) begin
            if (ring_index >= pattern_len) begin
               ring_index = '0;
            end
            // Drop the oldest letter once the window is full, else grow it
            if (window_len >= pattern_len) begin
               oldest = text_ring[ring_index];
               if (oldest < ALPHABET && window_hist[oldest] > 0) begin
                  window_hist[oldest]--;
               end
            end else begin
               window_len++;
            end
            text_ring[ring_index] = letter;
            window_hist[letter]++;
            ring_index++;
            if (ring_index >= pattern_len) begin
               ring_index = '0;
            end
            if (window_len == pattern_len) begin
               same = 1'b1;
               for (int i = 0; i < ALPHABET; i++) begin
                  if (pattern_hist[i] != window_hist[i]) begin
                     same = 1'b0;
                  end
               end
               if (same) begin
                  seen_match       = 1'b1;
                  rsp.window_match = 1'b1;
               end
            end
         end
      end
      rsp.found            = seen_match;
      rsp.pattern_overflow = pattern_spilled;
      return rsp;
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      end
      error_count++;
   endtask

   // Run away guard: end the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Check each accepted response against the oldest prediction, predict each
   // accepted request, and drive response ready with random stall bursts.
   // Responses are handled before requests so a same-edge request never
   // lines up with an older response.
   always @(posedge clock) begin : scoreboard
      rsp_word_type seen;
      rsp_word_type want;
      if (reset) begin
         clear_prediction();
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.window_match     = rsp_ch.window_match;
            seen.found            = rsp_ch.found;
            seen.pattern_overflow = rsp_ch.pattern_overflow;
            if (expected_rsp.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               want = expected_rsp.pop_front();
               if (seen.window_match !== want.window_match) begin
                  report_mismatch($sformatf("window_match %b, expected %b",
                                            seen.window_match, want.window_match));
               end
               if (seen.found !== want.found) begin
                  report_mismatch($sformatf("found %b, expected %b",
                                            seen.found, want.found));
               end
               if (seen.pattern_overflow !== want.pattern_overflow) begin
                  report_mismatch($sformatf("pattern_overflow %b, expected %b",
                                            seen.pattern_overflow, want.pattern_overflow));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_rsp.push_back(predict_response(req_ch.action, req_ch.letter));
         end
         // Hold ready low through a stall burst, otherwise start one now and then
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Present one request word and hold it until accepted. Valid stays high
   // between words unless an idle burst lowers it first.
   task automatic send_word(logic [1:0] action, logic [4:0] letter);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= action;
      req_ch.letter <= letter;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   // Occasionally slip a random word of any action and letter ahead of the intended one
   task automatic send_with_noise(logic [1:0] action, logic [4:0] letter);
      if ($urandom_range(0, 19) == 0) begin
         send_word(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
      end
      send_word(action, letter);
   endtask

   // Pause the sender until every predicted response has come back
   task automatic wait_for_responses();
      int waited;
      waited = 0;
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (expected_rsp.size() != 0 && waited < DRAIN_LIMIT);
      if (expected_rsp.size() != 0) begin
         report_mismatch($sformatf("%0d response words never arrived", expected_rsp.size()));
      end
   endtask

   // Ignored words: unused action, empty pattern, letters past z, begin
   task automatic test_ignored_words();
      send_word(ACT_UNUSED, 5'd31);
      send_word(ACT_TEXT, 5'd0);
      send_word(ACT_PATTERN, 5'd26);
      send_word(ACT_TEXT, 5'd31);
      send_word(ACT_BEGIN, 5'd31);
   endtask

   // Two-letter pattern at the alphabet ends, matching windows, late pattern letter
   task automatic test_window_match();
      send_word(ACT_PATTERN, 5'd25);
      send_word(ACT_PATTERN, 5'd0);
      send_word(ACT_TEXT, 5'd0);
      send_word(ACT_TEXT, 5'd25);
      send_word(ACT_TEXT, 5'd0);
      send_word(ACT_PATTERN, 5'd3);
      send_word(ACT_TEXT, 5'd1);
      send_word(ACT_TEXT, 5'd31);
      send_word(ACT_BEGIN, 5'd0);
   endtask

   // Pattern longer than the text never matches
   task automatic test_short_text();
      send_word(ACT_PATTERN, 5'd1);
      send_word(ACT_PATTERN, 5'd2);
      send_word(ACT_PATTERN, 5'd3);
      send_word(ACT_TEXT, 5'd3);
      send_word(ACT_TEXT, 5'd2);
      send_word(ACT_BEGIN, 5'd0);
   endtask

   // Send a shuffled copy of the first letters of the pattern, so a window matches
   task automatic send_permutation(logic [4:0] pattern [$]);
      logic [4:0] perm [$];
      logic [4:0] swap;
      int j;
      perm = pattern;
      while (perm.size() > MAX_PATTERN) begin
         void'(perm.pop_back());
      end
      for (int i = perm.size() - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         swap    = perm[i];
         perm[i] = perm[j];
         perm[j] = swap;
      end
      foreach (perm[i]) begin
         send_with_noise(ACT_TEXT, perm[i]);
      end
   endtask

   // Pattern past MAX_PATTERN letters: drop the extras, then match the truncated one
   task automatic test_pattern_overflow();
      logic [4:0] pattern [$];
      send_word(ACT_BEGIN, 5'($urandom_range(0, 31)));
      repeat (MAX_PATTERN + $urandom_range(1, 4)) begin
         pattern.push_back(5'($urandom_range(0, 5)));
         send_word(ACT_PATTERN, pattern[$]);
      end
      repeat ($urandom_range(0, 10)) send_word(ACT_TEXT, 5'($urandom_range(0, 5)));
      send_permutation(pattern);
      repeat ($urandom_range(1, 10)) send_word(ACT_TEXT, 5'($urandom_range(0, 5)));
   endtask

   // Begin, pattern, text sequences with random content; small alphabets and
   // embedded permutations keep matches frequent
   task automatic test_random_sequences(int word_budget);
      logic [4:0] pattern [$];
      int stop_at;
      int pick;
      int plen;
      int tlen;
      int span;
      int typed;
      stop_at = words_sent + word_budget;
      while (words_sent < stop_at) begin
         send_word(ACT_BEGIN, 5'($urandom_range(0, 31)));
         pick = $urandom_range(0, 39);
         if (pick == 0) begin
            plen = $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 6);
         end else if (pick < 6) begin
            plen = $urandom_range(0, 12);
         end else begin
            plen = $urandom_range(1, 6);
         end
         span = ($urandom_range(0, 3) == 0) ? ALPHABET : $urandom_range(1, 4);
         pattern.delete();
         repeat (plen) begin
            pattern.push_back(5'($urandom_range(0, span - 1)));
            send_with_noise(ACT_PATTERN, pattern[$]);
         end
         tlen  = $urandom_range(0, 3 * plen + 4);
         typed = 0;
         while (typed < tlen) begin
            if (plen > 0 && $urandom_range(0, 1) == 0) begin
               send_permutation(pattern);
               typed += (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
            end else begin
               send_with_noise(ACT_TEXT, 5'($urandom_range(0, span - 1)));
               typed++;
            end
         end
      end
   endtask

   // Stream with both sides always ready to cover full-rate acceptance
   task automatic test_back_to_back();
      no_idle = 1'b1;
      test_random_sequences(200);
   endtask

   initial begin
      req_ch.valid  <= 1'b0;
      req_ch.action <= ACT_BEGIN;
      req_ch.letter <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ignored_words();
      test_window_match();
      test_short_text();
      wait_for_responses();
      test_random_sequences(600);
      test_pattern_overflow();
      test_random_sequences(550);
      test_back_to_back();

      wait_for_responses();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
